### hw/rtl/length_crc_datagram_framer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length/CRC datagram framer
// Concurrent checks that drop out entirely when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef LENGTH_CRC_DATAGRAM_FRAMER_TOP_MACROS_SVH
`define LENGTH_CRC_DATAGRAM_FRAMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("framer assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### hw/rtl/ldf_pkg.sv
// ----------------------------------------------------------------------------
// ldf_pkg
// Types, constants and the CRC16 byte update shared by the framer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ldf_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] FRAME_OVERHEAD = 16'd4;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [11:0] payload_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       rejected;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_REJECT,
    CMD_START,
    CMD_DATA
  } cmd_kind_e;

  // one classified input word, as queued between front and back
  typedef struct packed {
    cmd_kind_e   kind;
    logic        last;
    logic [7:0]  data;
    logic [15:0] count;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_HEAD,
    ST_HDR_LO,
    ST_DATA,
    ST_CRC_HI,
    ST_CRC_LO
  } step_e;

  // CRC16-XMODEM, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ldf_front.sv
// ----------------------------------------------------------------------------
// ldf_front
// Accepts input words, tracks frame position and queues classified commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldf_front import ldf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 4092
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  input  wire logic     q_full_i,
  output logic          push_o,
  output cmd_t          cmd_o
);

  logic        inside_q, inside_d;
  logic [11:0] remaining_q, remaining_d;
  logic        accept;
  logic        len_bad;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  assign len_bad = (in_data_i.payload_length == 12'd0) ||
                   (17'(in_data_i.payload_length) > 17'(MAX_PAYLOAD));

  always_comb begin
    inside_d    = inside_q;
    remaining_d = remaining_q;
    cmd_o.data  = in_data_i.payload_byte;
    cmd_o.count = 16'(in_data_i.payload_length) + FRAME_OVERHEAD;
    if (!inside_q) begin
      if (len_bad) begin
        cmd_o.kind = CMD_REJECT;
        cmd_o.last = 1'b0;
      end else begin
        cmd_o.kind = CMD_START;
        cmd_o.last = (in_data_i.payload_length == 12'd1);
        if (accept) begin
          inside_d    = (in_data_i.payload_length != 12'd1);
          remaining_d = in_data_i.payload_length - 12'd1;
        end
      end
    end else begin
      cmd_o.kind = CMD_DATA;
      cmd_o.last = (remaining_q == 12'd1);
      if (accept) begin
        remaining_d = remaining_q - 12'd1;
        inside_d    = (remaining_q != 12'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q    <= 1'b0;
      remaining_q <= 12'd0;
    end else begin
      inside_q    <= inside_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ldf_queue.sv
// ----------------------------------------------------------------------------
// ldf_queue
// Small command FIFO between the front and back halves of the framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldf_queue import ldf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      head_valid_o,
  output cmd_t      head_o
);

  cmd_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;

  assign full_o       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ldf_back.sv
// ----------------------------------------------------------------------------
// ldf_back
// Expands queued commands into header, payload and CRC bytes on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldf_back import ldf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic head_valid_i,
  input  wire cmd_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_data_o
);

  step_e       step_q, step_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q;
  out_item_t   out_data_q;

  logic        load;
  logic        fire;
  out_item_t   emit;
  logic        crc_upd;
  logic        crc_clr;
  logic        pop_sel;

  // output register frees up when empty or being taken this cycle
  assign load = !out_valid_q || !out_stall_i;
  assign fire = head_valid_i && load;

  // next step
  always_comb begin
    step_d = step_q;
    if (fire) begin
      case (step_q)
        ST_HEAD: begin
          case (head_i.kind)
            CMD_START: step_d = ST_HDR_LO;
            CMD_DATA:  step_d = head_i.last ? ST_CRC_HI : ST_HEAD;
            default:   step_d = ST_HEAD;
          endcase
        end
        ST_HDR_LO: step_d = ST_DATA;
        ST_DATA:   step_d = head_i.last ? ST_CRC_HI : ST_HEAD;
        ST_CRC_HI: step_d = ST_CRC_LO;
        ST_CRC_LO: step_d = ST_HEAD;
        default:   step_d = ST_HEAD;
      endcase
    end
  end

  // outputs of each step
  always_comb begin
    emit    = '0;
    crc_upd = 1'b0;
    crc_clr = 1'b0;
    pop_sel = 1'b0;
    case (step_q)
      ST_HEAD: begin
        case (head_i.kind)
          CMD_START: begin
            emit.out_byte = head_i.count[15:8];
            crc_upd       = 1'b1;
          end
          CMD_DATA: begin
            emit.out_byte = head_i.data;
            crc_upd       = 1'b1;
            pop_sel       = !head_i.last;
          end
          default: begin
            emit.rejected = 1'b1;
            pop_sel       = 1'b1;
          end
        endcase
      end
      ST_HDR_LO: begin
        emit.out_byte = head_i.count[7:0];
        crc_upd       = 1'b1;
      end
      ST_DATA: begin
        emit.out_byte = head_i.data;
        crc_upd       = 1'b1;
        pop_sel       = !head_i.last;
      end
      ST_CRC_HI: begin
        emit.out_byte = crc_q[15:8];
      end
      ST_CRC_LO: begin
        emit.out_byte  = crc_q[7:0];
        emit.frame_end = 1'b1;
        crc_clr        = 1'b1;
        pop_sel        = 1'b1;
      end
      default: begin
        pop_sel = 1'b1;
      end
    endcase
  end

  assign pop_o = fire && pop_sel;

  always_comb begin
    crc_d = crc_q;
    if (fire && crc_clr) begin
      crc_d = 16'd0;
    end else if (fire && crc_upd) begin
      crc_d = crc16_byte(crc_q, emit.out_byte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_HEAD;
      crc_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      crc_q  <= crc_d;
      if (load) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### hw/rtl/length_crc_datagram_framer_top.sv
// ----------------------------------------------------------------------------
// length_crc_datagram_framer_top
// Length-prefixed datagram framer with big-endian CRC16-XMODEM trailer.
//
//   channel | dir | handshake             | word
//   in      | in  | in_valid_i/in_stall_o | in_item_t  (payload byte, length)
//   out     | out | out_valid_o/out_stall_i | out_item_t (byte, end, reject)
//
// Payload bytes pass at one word per cycle unless out_stall_i holds them;
// each frame adds four output words (two count, two CRC bytes) from the
// single output byte register of the back end. The 4-entry command queue
// absorbs input meanwhile, then stalls it. Input passes a queue entry and
// the output register. Reset is immediate, no clearing pass; out_stall_i
// only holds the output register and drains the queue at the output's pace.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "length_crc_datagram_framer_top_macros.svh"

module length_crc_datagram_framer_top import ldf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 4092
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_cmd;
  cmd_t q_head;
  logic rej_dirty;

  ldf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (q_cmd)
  );

  ldf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .cmd_i        (q_cmd),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  ldf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // a reject word carries no byte and never ends a frame
  assign rej_dirty = out_data_o.rejected &&
                     (out_data_o.out_byte != 8'd0 || out_data_o.frame_end);

  `ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, q_push && q_full)
  `ASSERT_NEVER(a_no_pop_when_empty, clk_i, rst_ni, q_pop && !q_head_valid)
  `ASSERT_NEVER(a_reject_word_clean, clk_i, rst_ni, out_valid_o && rej_dirty)

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the length/CRC datagram framer
// Drives payload words through the framer under varied input gaps and output
// stalls, and predicts every output word (count header, payload, CRC trailer,
// reject flag) in a scoreboard that checks the output stream in order.
// ----------------------------------------------------------------------------

module tb;
  import ldf_pkg::*;

  localparam int unsigned MAX_LEN = 4092;

  // Predicts framer output and checks it word by word.
  class framer_scoreboard;
    int unsigned max_len;
    bit          in_frame;
    logic [11:0] left;
    logic [15:0] crc;
    out_item_t   pending_q[$];
    int          mismatches;
    int          words_in;
    int          words_out;
    int          frames;
    int          rejects;

    function new(int unsigned m);
      max_len    = m;
      in_frame   = 1'b0;
      left       = '0;
      crc        = '0;
      mismatches = 0;
      words_in   = 0;
      words_out  = 0;
      frames     = 0;
      rejects    = 0;
    endfunction

    // bitwise CRC16-XMODEM update, MSB first
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int k = 7; k >= 0; k--) begin
        fb = r[15] ^ b[k];
        r  = {r[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
      end
      return r;
    endfunction

    function void queue_byte(logic [7:0] b, logic fe, logic rj);
      out_item_t o;
      o.out_byte  = b;
      o.frame_end = fe;
      o.rejected  = rj;
      pending_q.push_back(o);
    endfunction

    function void note_word(in_item_t w);
      logic [15:0] cnt;
      words_in++;
      if (!in_frame) begin
        if (w.payload_length == 12'd0 || w.payload_length > max_len) begin
          queue_byte(8'h00, 1'b0, 1'b1);
          rejects++;
          return;
        end
        cnt = {4'h0, w.payload_length} + 16'd4;
        crc = crc_step(crc_step(16'h0000, cnt[15:8]), cnt[7:0]);
        queue_byte(cnt[15:8], 1'b0, 1'b0);
        queue_byte(cnt[7:0], 1'b0, 1'b0);
        left     = w.payload_length;
        in_frame = 1'b1;
      end
      crc = crc_step(crc, w.payload_byte);
      queue_byte(w.payload_byte, 1'b0, 1'b0);
      left = left - 12'd1;
      if (left == 12'd0) begin
        queue_byte(crc[15:8], 1'b0, 1'b0);
        queue_byte(crc[7:0], 1'b1, 1'b0);
        in_frame = 1'b0;
        crc      = '0;
        frames++;
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("ERR @%0t: %s", $time, what);
    endtask

    task check_word(out_item_t got);
      out_item_t want;
      words_out++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected word byte=%02h end=%0b rej=%0b",
                         got.out_byte, got.frame_end, got.rejected));
        return;
      end
      want = pending_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("word %0d out_byte got %02h want %02h",
                         words_out, got.out_byte, want.out_byte));
      if (got.frame_end !== want.frame_end)
        report($sformatf("word %0d frame_end got %0b want %0b",
                         words_out, got.frame_end, want.frame_end));
      if (got.rejected !== want.rejected)
        report($sformatf("word %0d rejected got %0b want %0b",
                         words_out, got.rejected, want.rejected));
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      hold_on   = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int idle_pct  = 0;
  int stall_pct = 0;

  framer_scoreboard sb = new(MAX_LEN);

  length_crc_datagram_framer_top #(
    .MAX_PAYLOAD(MAX_LEN)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // receiver: random stall, or a solid hold-off when requested
  always @(posedge clk_i) begin
    if (hold_on) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // sample both handshakes at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_word(in_data);
      if (out_valid && !out_stall) sb.check_word(out_data);
    end
  end

  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic send_raw(input logic [7:0] b, input logic [11:0] len);
    in_item_t w;
    w.payload_byte   = b;
    w.payload_length = len;
    send_word(w);
  endtask

  // whole frame with random bytes; length field is noise after the first word
  task automatic send_frame(input int unsigned len);
    in_item_t w;
    for (int unsigned i = 0; i < len; i++) begin
      w.payload_byte   = 8'($urandom_range(255));
      w.payload_length = (i == 0) ? 12'(len) : 12'($urandom_range(4095));
      send_word(w);
    end
  endtask

  task automatic random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // bad start word
        send_raw(8'($urandom_range(255)),
                 (pick < 4) ? 12'd0 : 12'($urandom_range(4095, MAX_LEN + 1)));
        sent++;
      end else begin
        len = (pick < 90) ? $urandom_range(8, 1) : $urandom_range(40, 9);
        send_frame(len);
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: bad lengths, shortest frames, extreme bytes, noisy length fields
    send_raw(8'hFF, 12'd0);
    send_raw(8'h5A, 12'(MAX_LEN + 1));
    send_raw(8'h00, 12'hFFF);
    send_raw(8'h00, 12'd1);
    send_raw(8'hFF, 12'd1);
    send_raw(8'h12, 12'd2);
    send_raw(8'h34, 12'd0);
    send_raw(8'hFF, 12'd3);
    send_raw(8'h00, 12'hFFF);
    send_raw(8'hA5, 12'd0);
    send_raw(8'h80, 12'd0);
    send_raw(8'h01, 12'd1);

    idle_pct = 0;  stall_pct = 0;  random_traffic(40);
    idle_pct = 73; stall_pct = 0;  random_traffic(40);
    idle_pct = 0;  stall_pct = 73; random_traffic(40);
    idle_pct = 15; stall_pct = 15; random_traffic(40);

    // long receiver hold-off while the sender keeps pushing
    idle_pct = 0;  stall_pct = 0;
    fork
      begin
        for (int i = 0; i < 6; i++) send_frame(6);
      end
      begin
        hold_on <= 1'b1;
        repeat (250) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join

    in_valid  <= 1'b0;
    stall_pct = 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Run: %0d input words, %0d output words, %0d frames, %0d bad starts",
             sb.words_in, sb.words_out, sb.frames, sb.rejects);
    $display("Covered gaps, stalls, mixed idling, bad lengths and a full hold-off");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ldf_pkg.sv
hw/rtl/ldf_front.sv
hw/rtl/ldf_queue.sv
hw/rtl/ldf_back.sv
hw/rtl/length_crc_datagram_framer_top.sv
verif/tb.sv
